[sv/chipset_memory_decoder_with_config_regs_core_defines.svh]
// assertion macros for the chipset memory decoder
`ifndef CHIPSET_MEMORY_DECODER_WITH_CONFIG_REGS_CORE_DEFINES_SVH
`define CHIPSET_MEMORY_DECODER_WITH_CONFIG_REGS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CMDEC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cmdec assertion failed");
`define CMDEC_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cmdec assertion failed");
`else
`define CMDEC_ASSERT(lbl, clk, rstn, prop)
`define CMDEC_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

[sv/cmdec_pkg.sv]
package cmdec_pkg;

  localparam int unsigned ConfigEntries = 128;
  localparam int unsigned CfgIdxW       = $clog2(ConfigEntries);

  // func codes
  localparam logic [2:0] FnIoRd  = 3'd0;
  localparam logic [2:0] FnIoWr  = 3'd1;
  localparam logic [2:0] FnMemRd = 3'd2;
  localparam logic [2:0] FnMemWr = 3'd3;
  localparam logic [2:0] FnTick  = 3'd4;

  // route codes
  localparam logic [2:0] RtDram  = 3'd0;
  localparam logic [2:0] RtRom   = 3'd1;
  localparam logic [2:0] RtExt   = 3'd2;
  localparam logic [2:0] RtOpen  = 3'd3;
  localparam logic [2:0] RtBreak = 3'd4;
  localparam logic [2:0] RtInt   = 3'd5;
  localparam logic [2:0] RtIoun  = 3'd6;

  // configuration port register indexes
  localparam logic [2:0] RegBank0 = 3'd0;
  localparam logic [2:0] RegBank1 = 3'd1;
  localparam logic [2:0] RegBank2 = 3'd2;
  localparam logic [2:0] RegBank3 = 3'd3;
  localparam logic [2:0] RegMode  = 3'd4;
  localparam logic [2:0] RegTotal = 3'd5;

  // io ports and file indexes
  localparam logic [15:0] PortIndex = 16'h0022;
  localparam logic [15:0] PortData  = 16'h0023;
  localparam logic [7:0]  IdxMode   = 8'h10;
  localparam logic [7:0]  IdxShd0   = 8'h12;
  localparam logic [7:0]  IdxLock   = 8'h13;
  localparam logic [7:0]  IdxShd1   = 8'h14;
  localparam logic [7:0]  IdxShd2   = 8'h15;
  localparam logic [7:0]  IdxRefr   = 8'h20;
  localparam logic [7:0]  IdxMisc   = 8'h3C;
  localparam logic [7:0]  UnlockKey = 8'hC5;
  localparam logic [7:0]  LockKey   = 8'h00;

  localparam logic [4:0] ModeBank29 = 5'd29;
  localparam logic [4:0] ModeBank31 = 5'd31;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [22:0] off;
  } bank_off_t;

  function automatic logic [7:0] cfg_default(input logic [CfgIdxW-1:0] idx);
    logic [7:0] v;
    v = 8'hFF;
    case (idx) inside
      7'h11: v = 8'hF8;
      7'h12: v = 8'h10;
      7'h18, 7'h1B: v = 8'hF0;
      7'h20: v = 8'h80;
      7'h30: v = 8'h08;
      7'h31: v = 8'h01;
      7'h10, [7'h13:7'h16], 7'h19, 7'h1C, 7'h1E, [7'h32:7'h3F], [7'h55:7'h5E],
      7'h64, [7'h66:7'h73]: v = 8'h00;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

  function automatic bank_off_t bank_off(input logic [4:0] code, input logic odd,
                                         input logic [12:0] lo, input logic [13:0] hi);
    bank_off_t r;
    r.ok  = 1'b1;
    r.off = '0;
    unique case (code)
      5'd18: r.off = 23'(lo[9:0]) + (23'(hi[8:0]) << 9);
      5'd19: begin
        r.ok  = odd;
        r.off = 23'(lo[9:0]) + (23'(hi[9:0]) << 9);
      end
      5'd20: r.off = 23'(lo[10:0]) + (23'(hi[9:0]) << 10);
      5'd21: begin
        r.ok  = odd;
        r.off = 23'(lo[10:0]) + (23'(hi[10:0]) << 10);
      end
      5'd22: r.off = 23'(lo[11:0]) + (23'(hi[10:0]) << 11);
      default: r.ok = 1'b0;
    endcase
    if (!r.ok) begin
      r.off = '0;
    end
    return r;
  endfunction

endpackage

[sv/chipset_memory_decoder_with_config_regs_core.sv]
// channel   signals                                          timing
// ------    -----------------------------------------------  ---------------------------
// item      start, busy, func_i, address_i, data_in_i,       taken when start & !busy
//           a20_enabled_i
// result    done_o, route_o, target_offset_o, data_value_o,  one cycle strobe on done_o
//           refresh_level_o
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i                 written when cfg_we_i
//
// each beat is captured, then decoded and committed while the
// config file read at the current index comes out of its registered port
// the result strobe is registered from the execute state; a new item is
// taken in the cycle of that strobe
// reset leaves the file at its defaults through per-entry valid bits, no
// clearing pass; the result side cannot stall
`include "chipset_memory_decoder_with_config_regs_core_defines.svh"

module chipset_memory_decoder_with_config_regs_core #(
  parameter int unsigned REFRESH_DIVIDE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  data_in_i,
  input  logic        a20_enabled_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [25:0] cfg_wdata_i,
  output logic        done_o,
  output logic [2:0]  route_o,
  output logic [31:0] target_offset_o,
  output logic [7:0]  data_value_o,
  output logic        refresh_level_o
);

  cmdec_pkg::cmd_t cmd;

  cmdec_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  cmdec_dp #(
    .REFRESH_DIVIDE (REFRESH_DIVIDE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .address_i       (address_i),
    .data_in_i       (data_in_i),
    .a20_enabled_i   (a20_enabled_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .route_o         (route_o),
    .target_offset_o (target_offset_o),
    .data_value_o    (data_value_o),
    .refresh_level_o (refresh_level_o)
  );

  // accepted beat always produces a strobe after its execute state
  `CMDEC_ASSERT(a_accept_done, clk_i, rst_ni, (start && !busy) |=> ##1 done_o)
  // strobe only ends an execute cycle
  `CMDEC_ASSERT(a_done_after_exec, clk_i, rst_ni, done_o |-> $past(cmd.execute))
  // capture and execute never overlap
  `CMDEC_ASSERT(a_cmd_excl, clk_i, rst_ni, !(cmd.capture && cmd.execute))
  // refresh level only moves with a result
  `CMDEC_ASSERT(a_refresh_moves, clk_i, rst_ni, !$stable(refresh_level_o) |-> done_o)

endmodule

[sv/cmdec_ctrl.sv]
module cmdec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output cmdec_pkg::cmd_t   cmd_o
);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            state_q <= StExec;
            busy_q  <= 1'b1;
          end
        end
        StExec: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy          = busy_q;
  assign done_o        = done_q;
  assign cmd_o.capture = start && !busy_q;
  assign cmd_o.execute = (state_q == StExec);

endmodule

[sv/cmdec_dp.sv]
module cmdec_dp #(
  parameter int unsigned REFRESH_DIVIDE = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmdec_pkg::cmd_t  cmd_i,
  input  logic [2:0]       func_i,
  input  logic [31:0]      address_i,
  input  logic [7:0]       data_in_i,
  input  logic             a20_enabled_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [25:0]      cfg_wdata_i,
  output logic [2:0]       route_o,
  output logic [31:0]      target_offset_o,
  output logic [7:0]       data_value_o,
  output logic             refresh_level_o
);

  localparam int unsigned IdxW = cmdec_pkg::CfgIdxW;
  localparam int unsigned Entries = cmdec_pkg::ConfigEntries;
  localparam int unsigned DivW = (REFRESH_DIVIDE > 1) ? $clog2(REFRESH_DIVIDE) : 1;
  localparam logic [DivW-1:0] DivLast = DivW'(REFRESH_DIVIDE - 1);

  // configuration registers
  logic [4:0]  bank_q [4];
  logic [4:0]  inst_mode_q;
  logic [25:0] total_q;

  // captured item
  logic [2:0]  func_q;
  logic [31:0] addr_q;
  logic [7:0]  din_q;
  logic        a20_q;

  // chipset state
  logic [7:0]         idx_q;
  logic               locked_q;
  logic               mode_valid_q;
  logic [DivW-1:0]    div_q;
  logic               toggle_q;
  logic [Entries-1:0] valid_q;
  logic [7:0]         mem_q [Entries];
  logic [7:0]         rd_q;
  logic [7:0]         r10_q, r12_q, r14_q, r15_q, r20_q, r3c_q;

  // results
  logic [2:0]  route_q;
  logic [31:0] off_q;
  logic [7:0]  data_q;

  logic [2:0]  route_d;
  logic [31:0] off_d;
  logic [7:0]  data_d;
  logic        file_we;
  logic        idx_we;
  logic        lock_set;
  logic        lock_clr;
  logic        tick;
  logic        tick_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        bank_q[i] <= '0;
      end
      inst_mode_q <= '0;
      total_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmdec_pkg::RegBank0: bank_q[0] <= cfg_wdata_i[4:0];
        cmdec_pkg::RegBank1: bank_q[1] <= cfg_wdata_i[4:0];
        cmdec_pkg::RegBank2: bank_q[2] <= cfg_wdata_i[4:0];
        cmdec_pkg::RegBank3: bank_q[3] <= cfg_wdata_i[4:0];
        cmdec_pkg::RegMode:  inst_mode_q <= cfg_wdata_i[4:0];
        cmdec_pkg::RegTotal: total_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      addr_q <= address_i;
      din_q  <= data_in_i;
      a20_q  <= a20_enabled_i;
    end
  end

  // config file storage, registered read at the current index
  always_ff @(posedge clk_i) begin
    if (file_we) begin
      mem_q[idx_q[IdxW-1:0]] <= din_q;
    end
    rd_q <= mem_q[idx_q[IdxW-1:0]];
  end

  // routing
  logic [15:0]             port;
  logic [23:0]             ads;
  logic [31:0]             a_m;
  logic                    wr;
  logic [4:0]              seg;
  logic [2:0]              bsel;
  logic [7:0]              file_rd;
  logic [4:0]              bmode;
  logic [2:0]              dram_rt;
  logic [31:0]             dram_off;
  cmdec_pkg::bank_off_t    boff;

  always_comb begin
    port  = addr_q[15:0];
    ads   = addr_q[23:0];
    wr    = (func_q == cmdec_pkg::FnMemWr);
    seg   = ads[19:15];
    bsel  = {seg[1:0], wr};
    bmode = r10_q[7:3];
    a_m   = addr_q;
    if (!a20_q) begin
      a_m[20] = 1'b0;
    end

    if (bmode == cmdec_pkg::ModeBank29) begin
      boff = cmdec_pkg::bank_off(a_m[12] ? bank_q[3] : bank_q[2], 1'b0,
                                 {1'b0, a_m[11:0]}, a_m[27:14]);
    end else begin
      boff = cmdec_pkg::bank_off(a_m[13] ? bank_q[1] : bank_q[0], 1'b1,
                                 a_m[12:0], a_m[27:14]);
    end

    dram_rt  = cmdec_pkg::RtOpen;
    dram_off = '0;
    if (r3c_q[1]) begin
      dram_rt = cmdec_pkg::RtOpen;
    end else if (mode_valid_q) begin
      dram_off = a_m;
      dram_rt  = (a_m < {6'd0, total_q}) ? cmdec_pkg::RtDram : cmdec_pkg::RtExt;
    end else if (bmode == cmdec_pkg::ModeBank29 && !a_m[13]) begin
      dram_rt = cmdec_pkg::RtOpen;
    end else if (bmode == cmdec_pkg::ModeBank29 || bmode == cmdec_pkg::ModeBank31) begin
      dram_rt  = boff.ok ? cmdec_pkg::RtDram : cmdec_pkg::RtOpen;
      dram_off = {9'd0, boff.off};
    end else begin
      dram_off = a_m;
      dram_rt  = cmdec_pkg::RtExt;
    end

    if (locked_q || idx_q[7]) begin
      file_rd = 8'hFF;
    end else if (valid_q[idx_q[IdxW-1:0]]) begin
      file_rd = rd_q;
    end else begin
      file_rd = cmdec_pkg::cfg_default(idx_q[IdxW-1:0]);
    end

    route_d  = cmdec_pkg::RtInt;
    off_d    = '0;
    data_d   = '0;
    file_we  = 1'b0;
    idx_we   = 1'b0;
    lock_set = 1'b0;
    lock_clr = 1'b0;
    tick     = 1'b0;

    case (func_q)
      cmdec_pkg::FnIoRd: begin
        off_d = {16'd0, port};
        if (port == cmdec_pkg::PortIndex) begin
          data_d = idx_q;
        end else if (port == cmdec_pkg::PortData) begin
          data_d = file_rd;
        end else begin
          route_d = cmdec_pkg::RtIoun;
          data_d  = 8'hFF;
        end
      end
      cmdec_pkg::FnIoWr: begin
        off_d  = {16'd0, port};
        data_d = din_q;
        if (port == cmdec_pkg::PortIndex) begin
          idx_we = 1'b1;
        end else if (port == cmdec_pkg::PortData) begin
          if (idx_q == cmdec_pkg::IdxLock) begin
            lock_clr = (din_q == cmdec_pkg::UnlockKey);
            lock_set = (din_q == cmdec_pkg::LockKey);
          end else begin
            file_we = !locked_q && !idx_q[7];
          end
        end else begin
          route_d = cmdec_pkg::RtIoun;
        end
      end
      cmdec_pkg::FnMemRd, cmdec_pkg::FnMemWr: begin
        if (ads >= 24'hFE0000) begin
          route_d = wr ? cmdec_pkg::RtOpen : cmdec_pkg::RtRom;
          off_d   = wr ? 32'd0 : {15'd0, ads[16:0]};
        end else if (ads >= 24'h100000 || ads < 24'h0A0000) begin
          route_d = dram_rt;
          off_d   = dram_off;
        end else if (seg < 5'd24) begin
          if (r3c_q[3] && r12_q[1]) begin
            route_d = dram_rt;
            off_d   = dram_off;
          end else begin
            route_d = cmdec_pkg::RtExt;
            off_d   = addr_q;
          end
        end else if (seg < 5'd28) begin
          if (r14_q[bsel]) begin
            route_d = dram_rt;
            off_d   = dram_off;
          end else begin
            route_d = cmdec_pkg::RtExt;
            off_d   = addr_q;
          end
        end else begin
          if (r15_q[bsel]) begin
            route_d = dram_rt;
            off_d   = dram_off;
          end else begin
            route_d = wr ? cmdec_pkg::RtBreak : cmdec_pkg::RtRom;
            off_d   = {15'd0, ads[16:0]};
          end
        end
        if (wr) begin
          data_d = din_q;
        end else if (route_d == cmdec_pkg::RtOpen) begin
          data_d = 8'hFF;
        end
      end
      cmdec_pkg::FnTick: tick = 1'b1;
      default: ;
    endcase
  end

  assign tick_wrap = (div_q == DivLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      locked_q     <= 1'b1;
      mode_valid_q <= 1'b0;
      div_q        <= '0;
      toggle_q     <= 1'b0;
      valid_q      <= '0;
      r10_q        <= cmdec_pkg::cfg_default(IdxW'(cmdec_pkg::IdxMode));
      r12_q        <= cmdec_pkg::cfg_default(IdxW'(cmdec_pkg::IdxShd0));
      r14_q        <= cmdec_pkg::cfg_default(IdxW'(cmdec_pkg::IdxShd1));
      r15_q        <= cmdec_pkg::cfg_default(IdxW'(cmdec_pkg::IdxShd2));
      r20_q        <= cmdec_pkg::cfg_default(IdxW'(cmdec_pkg::IdxRefr));
      r3c_q        <= cmdec_pkg::cfg_default(IdxW'(cmdec_pkg::IdxMisc));
    end else if (cmd_i.execute) begin
      if (idx_we) begin
        idx_q <= din_q;
      end
      if (lock_clr) begin
        locked_q <= 1'b0;
      end else if (lock_set) begin
        locked_q <= 1'b1;
      end
      if (file_we) begin
        valid_q[idx_q[IdxW-1:0]] <= 1'b1;
        case (idx_q)
          cmdec_pkg::IdxMode: begin
            r10_q        <= din_q;
            mode_valid_q <= (din_q[7:3] == inst_mode_q);
          end
          cmdec_pkg::IdxShd0: r12_q <= din_q;
          cmdec_pkg::IdxShd1: r14_q <= din_q;
          cmdec_pkg::IdxShd2: r15_q <= din_q;
          cmdec_pkg::IdxRefr: r20_q <= din_q;
          cmdec_pkg::IdxMisc: r3c_q <= din_q;
          default: ;
        endcase
      end
      if (tick) begin
        if (tick_wrap) begin
          div_q <= '0;
          if (r20_q[7]) begin
            toggle_q <= !toggle_q;
          end
        end else begin
          div_q <= div_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      route_q <= route_d;
      off_q   <= off_d;
      data_q  <= data_d;
    end
  end

  assign route_o         = route_q;
  assign target_offset_o = off_q;
  assign data_value_o    = data_q;
  assign refresh_level_o = toggle_q;

endmodule

[bench/chipset_memory_decoder_with_config_regs_core_tb.sv]
`timescale 1ns / 100ps

module chipset_memory_decoder_with_config_regs_core_tb;

  localparam int unsigned RefreshDivide = 16;
  localparam logic [2:0] FnUnused = 3'd7;

  typedef struct packed {
    logic [2:0]  route;
    logic [31:0] offset;
    logic [7:0]  data;
    logic        refresh;
  } bus_result_t;

  typedef struct {
    logic [2:0]  fn;
    logic [31:0] addr;
    logic [7:0]  din;
    logic        a20;
    bit          known;
    logic [2:0]  rt;
    logic [31:0] off;
    logic [7:0]  dv;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func_i = '0;
  logic [31:0] address_i = '0;
  logic [7:0]  data_in_i = '0;
  logic        a20_enabled_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [25:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [2:0]  route_o;
  logic [31:0] target_offset_o;
  logic [7:0]  data_value_o;
  logic        refresh_level_o;

  chipset_memory_decoder_with_config_regs_core #(
    .REFRESH_DIVIDE(RefreshDivide)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .address_i      (address_i),
    .data_in_i      (data_in_i),
    .a20_enabled_i  (a20_enabled_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .route_o        (route_o),
    .target_offset_o(target_offset_o),
    .data_value_o   (data_value_o),
    .refresh_level_o(refresh_level_o)
  );

  // shadow of the decoder state
  logic [4:0]  bank_code [4];
  logic [4:0]  inst_mode;
  logic [25:0] dram_bytes;
  logic [7:0]  cfg_index;
  logic        cfg_locked;
  logic [7:0]  cfg_file [cmdec_pkg::ConfigEntries];
  logic        linear_ok;
  int unsigned tick_count;
  logic        refresh_q;

  bus_result_t expected_routes[$];
  bus_result_t seen_want;
  int          mismatch_count = 0;
  int          beats_sent = 0;
  int          results_seen = 0;
  int          config_loads = 0;
  int          gap_pct = 0;
  int          route_hits [8];

  dir_row_t dir_rows [27] = '{
    '{cmdec_pkg::FnIoRd, {16'h0, cmdec_pkg::PortIndex}, 8'h00, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortIndex}, 8'h00},
    '{cmdec_pkg::FnIoRd, {16'h0, cmdec_pkg::PortData}, 8'h00, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortData}, 8'hFF},
    '{cmdec_pkg::FnIoRd, 32'hABCD_1234, 8'h00, 1'b0, 1'b1,
      cmdec_pkg::RtIoun, 32'h0000_1234, 8'hFF},
    '{cmdec_pkg::FnIoWr, 32'hFFFF_FFFF, 8'hAA, 1'b1, 1'b1,
      cmdec_pkg::RtIoun, 32'h0000_FFFF, 8'hAA},
    '{cmdec_pkg::FnMemRd, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1,
      cmdec_pkg::RtRom, 32'h0001_FFFF, 8'h00},
    '{cmdec_pkg::FnMemWr, 32'h00FE_0000, 8'h55, 1'b1, 1'b1,
      cmdec_pkg::RtOpen, 32'h0, 8'h55},
    '{cmdec_pkg::FnMemRd, 32'h0000_0000, 8'h00, 1'b0, 1'b1,
      cmdec_pkg::RtExt, 32'h0, 8'h00},
    '{cmdec_pkg::FnMemRd, 32'h000F_0000, 8'h00, 1'b1, 1'b1,
      cmdec_pkg::RtRom, 32'h0001_0000, 8'h00},
    '{cmdec_pkg::FnMemWr, 32'h000F_8000, 8'h12, 1'b1, 1'b1,
      cmdec_pkg::RtBreak, 32'h0001_8000, 8'h12},
    '{cmdec_pkg::FnMemRd, 32'h000A_0000, 8'h00, 1'b1, 1'b1,
      cmdec_pkg::RtExt, 32'h000A_0000, 8'h00},
    '{cmdec_pkg::FnTick, 32'h0, 8'h00, 1'b0, 1'b1,
      cmdec_pkg::RtInt, 32'h0, 8'h00},
    '{FnUnused, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1,
      cmdec_pkg::RtInt, 32'h0, 8'h00},
    '{cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortIndex}, cmdec_pkg::IdxLock, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortIndex}, cmdec_pkg::IdxLock},
    '{cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortData}, cmdec_pkg::UnlockKey, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortData}, cmdec_pkg::UnlockKey},
    '{cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortIndex}, 8'h80, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortIndex}, 8'h80},
    '{cmdec_pkg::FnIoRd, {16'h0, cmdec_pkg::PortData}, 8'h00, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortData}, 8'hFF},
    '{cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortData}, 8'h77, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortData}, 8'h77},
    '{cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortIndex}, cmdec_pkg::IdxMode, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortIndex}, cmdec_pkg::IdxMode},
    '{cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortData}, 8'hE8, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortData}, 8'hE8},
    '{cmdec_pkg::FnMemRd, 32'h0010_2000, 8'h00, 1'b1, 1'b0,
      cmdec_pkg::RtDram, 32'h0, 8'h00},
    '{cmdec_pkg::FnMemRd, 32'h0010_3000, 8'h00, 1'b1, 1'b0,
      cmdec_pkg::RtDram, 32'h0, 8'h00},
    '{cmdec_pkg::FnMemRd, 32'h0010_0000, 8'h00, 1'b1, 1'b1,
      cmdec_pkg::RtOpen, 32'h0, 8'hFF},
    '{cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortData}, 8'hF8, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortData}, 8'hF8},
    '{cmdec_pkg::FnMemWr, 32'h0010_2000, 8'h3C, 1'b1, 1'b0,
      cmdec_pkg::RtDram, 32'h0, 8'h00},
    '{cmdec_pkg::FnMemRd, 32'h0010_0000, 8'h00, 1'b1, 1'b0,
      cmdec_pkg::RtDram, 32'h0, 8'h00},
    '{cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortIndex}, cmdec_pkg::IdxLock, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortIndex}, cmdec_pkg::IdxLock},
    '{cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortData}, cmdec_pkg::LockKey, 1'b1, 1'b1,
      cmdec_pkg::RtInt, {16'h0, cmdec_pkg::PortData}, cmdec_pkg::LockKey}
  };

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", expected_routes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s at result %0d: got %0h want %0h", what, results_seen, got, want);
    mismatch_count++;
  endtask

  function automatic void reset_decoder_model();
    for (int i = 0; i < cmdec_pkg::ConfigEntries; i++) begin
      if (i == 'h10 || (i >= 'h13 && i <= 'h16) || i == 'h19 || i == 'h1C || i == 'h1E ||
          (i >= 'h32 && i <= 'h3F) || (i >= 'h55 && i <= 'h5E) || i == 'h64 ||
          (i >= 'h66 && i <= 'h73)) begin
        cfg_file[i] = 8'h00;
      end else begin
        cfg_file[i] = 8'hFF;
      end
    end
    cfg_file['h11] = 8'hF8;
    cfg_file['h12] = 8'h10;
    cfg_file['h18] = 8'hF0;
    cfg_file['h1B] = 8'hF0;
    cfg_file['h20] = 8'h80;
    cfg_file['h30] = 8'h08;
    cfg_file['h31] = 8'h01;
    for (int b = 0; b < 4; b++) bank_code[b] = '0;
    inst_mode  = '0;
    dram_bytes = '0;
    cfg_index  = '0;
    cfg_locked = 1'b1;
    linear_ok  = 1'b0;
    tick_count = 0;
    refresh_q  = 1'b0;
  endfunction

  function automatic logic bank_offset(input logic [4:0] code, input logic odd,
                                       input logic [31:0] lo, input logic [31:0] hi,
                                       output logic [31:0] off);
    off = '0;
    case (code)
      5'd18: off = (lo & 32'h3FF) + ((hi & 32'h1FF) << 9);
      5'd19: off = (lo & 32'h3FF) + ((hi & 32'h3FF) << 9);
      5'd20: off = (lo & 32'h7FF) + ((hi & 32'h3FF) << 10);
      5'd21: off = (lo & 32'h7FF) + ((hi & 32'h7FF) << 10);
      5'd22: off = (lo & 32'hFFF) + ((hi & 32'h7FF) << 11);
      default: return 1'b0;
    endcase
    if ((code == 5'd19 || code == 5'd21) && !odd) begin
      off = '0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [2:0] dram_path(input logic [31:0] a_in, input logic a20,
                                           output logic [31:0] off);
    logic [31:0] a;
    logic [31:0] hi;
    logic [4:0]  mode;
    logic        ok;
    off = '0;
    if (cfg_file[cmdec_pkg::IdxMisc[6:0]][1]) return cmdec_pkg::RtOpen;
    a = a20 ? a_in : (a_in & 32'hFFEF_FFFF);
    if (linear_ok) begin
      off = a;
      return (a < {6'h0, dram_bytes}) ? cmdec_pkg::RtDram : cmdec_pkg::RtExt;
    end
    mode = cfg_file[cmdec_pkg::IdxMode[6:0]][7:3];
    hi = (a & 32'h0FFF_C000) >> 14;
    if (mode == cmdec_pkg::ModeBank29) begin
      if (!a[13]) return cmdec_pkg::RtOpen;
      ok = bank_offset(a[12] ? bank_code[3] : bank_code[2], 1'b0, a & 32'hFFF, hi, off);
    end else if (mode == cmdec_pkg::ModeBank31) begin
      ok = bank_offset(a[13] ? bank_code[1] : bank_code[0], 1'b1, a & 32'h1FFF, hi, off);
    end else begin
      off = a;
      return cmdec_pkg::RtExt;
    end
    if (!ok) begin
      off = '0;
      return cmdec_pkg::RtOpen;
    end
    return cmdec_pkg::RtDram;
  endfunction

  function automatic logic [2:0] mem_path(input logic [31:0] a, input logic wr,
                                          input logic a20, output logic [31:0] off);
    logic [23:0] ads;
    logic [4:0]  seg;
    logic [2:0]  sel;
    ads = a[23:0];
    off = '0;
    if (ads >= 24'hFE0000) begin
      if (wr) return cmdec_pkg::RtOpen;
      off = {15'h0, ads[16:0]};
      return cmdec_pkg::RtRom;
    end
    if (ads >= 24'h100000 || ads < 24'h0A0000) return dram_path(a, a20, off);
    seg = ads[19:15];
    sel = {seg[1:0], wr};
    if (seg < 5'd24) begin
      if (cfg_file[cmdec_pkg::IdxMisc[6:0]][3] && cfg_file[cmdec_pkg::IdxShd0[6:0]][1])
        return dram_path(a, a20, off);
      off = a;
      return cmdec_pkg::RtExt;
    end
    if (seg < 5'd28) begin
      if (cfg_file[cmdec_pkg::IdxShd1[6:0]][sel]) return dram_path(a, a20, off);
      off = a;
      return cmdec_pkg::RtExt;
    end
    if (cfg_file[cmdec_pkg::IdxShd2[6:0]][sel]) return dram_path(a, a20, off);
    off = {15'h0, ads[16:0]};
    return wr ? cmdec_pkg::RtBreak : cmdec_pkg::RtRom;
  endfunction

  function automatic bus_result_t decode_access(input logic [2:0] fn, input logic [31:0] addr,
                                                input logic [7:0] din, input logic a20);
    bus_result_t r;
    logic [15:0] port;
    port = addr[15:0];
    r = '0;
    r.route = cmdec_pkg::RtInt;
    case (fn)
      cmdec_pkg::FnIoRd: begin
        r.offset = {16'h0, port};
        if (port == cmdec_pkg::PortIndex) begin
          r.data = cfg_index;
        end else if (port == cmdec_pkg::PortData) begin
          r.data = (cfg_locked || cfg_index >= 8'(cmdec_pkg::ConfigEntries)) ?
                   8'hFF : cfg_file[cfg_index[6:0]];
        end else begin
          r.route = cmdec_pkg::RtIoun;
          r.data = 8'hFF;
        end
      end
      cmdec_pkg::FnIoWr: begin
        r.offset = {16'h0, port};
        r.data = din;
        if (port == cmdec_pkg::PortIndex) begin
          cfg_index = din;
        end else if (port == cmdec_pkg::PortData) begin
          if (cfg_index == cmdec_pkg::IdxLock) begin
            if (din == cmdec_pkg::UnlockKey) cfg_locked = 1'b0;
            else if (din == cmdec_pkg::LockKey) cfg_locked = 1'b1;
          end else if (!cfg_locked && cfg_index < 8'(cmdec_pkg::ConfigEntries)) begin
            cfg_file[cfg_index[6:0]] = din;
            if (cfg_index == cmdec_pkg::IdxMode) linear_ok = (din[7:3] == inst_mode);
          end
        end else begin
          r.route = cmdec_pkg::RtIoun;
        end
      end
      cmdec_pkg::FnMemRd, cmdec_pkg::FnMemWr: begin
        r.route = mem_path(addr, fn == cmdec_pkg::FnMemWr, a20, r.offset);
        if (fn == cmdec_pkg::FnMemWr) r.data = din;
        else if (r.route == cmdec_pkg::RtOpen) r.data = 8'hFF;
      end
      cmdec_pkg::FnTick: begin
        tick_count++;
        if (tick_count >= RefreshDivide) begin
          tick_count = 0;
          if (cfg_file[cmdec_pkg::IdxRefr[6:0]][7]) refresh_q = ~refresh_q;
        end
      end
      default: ;
    endcase
    r.refresh = refresh_q;
    return r;
  endfunction

  // hold the sender until every expected beat has come back
  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_routes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [2:0] idx, input logic [25:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      cmdec_pkg::RegBank0: bank_code[0] = val[4:0];
      cmdec_pkg::RegBank1: bank_code[1] = val[4:0];
      cmdec_pkg::RegBank2: bank_code[2] = val[4:0];
      cmdec_pkg::RegBank3: bank_code[3] = val[4:0];
      cmdec_pkg::RegMode:  inst_mode = val[4:0];
      cmdec_pkg::RegTotal: dram_bytes = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [4:0] c0, input logic [4:0] c1, input logic [4:0] c2,
                             input logic [4:0] c3, input logic [4:0] mode,
                             input logic [25:0] total);
    quiesce();
    cfg_put(cmdec_pkg::RegBank0, {21'h0, c0});
    cfg_put(cmdec_pkg::RegBank1, {21'h0, c1});
    cfg_put(cmdec_pkg::RegBank2, {21'h0, c2});
    cfg_put(cmdec_pkg::RegBank3, {21'h0, c3});
    cfg_put(cmdec_pkg::RegMode, {21'h0, mode});
    cfg_put(cmdec_pkg::RegTotal, total);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    config_loads++;
  endtask

  task automatic send_beat(input logic [2:0] fn, input logic [31:0] addr, input logic [7:0] din,
                           input logic a20, input bit known, input bus_result_t known_res);
    bus_result_t res;
    if (gap_pct != 0 && $urandom_range(0, 99) < 2) begin
      quiesce();
    end else if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start         <= 1'b1;
    func_i        <= fn;
    address_i     <= addr;
    data_in_i     <= din;
    a20_enabled_i <= a20;
    do @(posedge clk_i); while (busy);
    res = decode_access(fn, addr, din, a20);
    expected_routes.push_back(known ? known_res : res);
    beats_sent++;
  endtask

  task automatic run_random(input int n);
    int          target;
    int          r;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [7:0]  upper;
    logic [31:0] addr;
    logic [4:0]  mode;
    target = beats_sent + n;
    while (beats_sent < target) begin
      r = $urandom_range(0, 99);
      upper = 8'($urandom);
      if (r < 10) begin
        // unlock or lock sequence
        send_beat(cmdec_pkg::FnIoWr, {upper, 8'h0, cmdec_pkg::PortIndex}, cmdec_pkg::IdxLock,
                  1'($urandom), 1'b0, '0);
        r = $urandom_range(0, 99);
        val = (r < 70) ? cmdec_pkg::UnlockKey : (r < 85) ? cmdec_pkg::LockKey : 8'($urandom);
        send_beat(cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortData}, val, 1'($urandom),
                  1'b0, '0);
      end else if (r < 30) begin
        val = 8'($urandom);
        case ($urandom_range(0, 6))
          0: begin
            idx = cmdec_pkg::IdxMode;
            case ($urandom_range(0, 3))
              0: mode = cmdec_pkg::ModeBank29;
              1: mode = cmdec_pkg::ModeBank31;
              2: mode = inst_mode;
              default: mode = 5'($urandom);
            endcase
            val = {mode, val[2:0]};
          end
          1: idx = cmdec_pkg::IdxShd0;
          2: idx = cmdec_pkg::IdxShd1;
          3: idx = cmdec_pkg::IdxShd2;
          4: idx = cmdec_pkg::IdxRefr;
          5: begin
            idx = cmdec_pkg::IdxMisc;
            if ($urandom_range(0, 3) != 0) val[1] = 1'b0;
          end
          default: idx = 8'($urandom);
        endcase
        send_beat(cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortIndex}, idx, 1'($urandom),
                  1'b0, '0);
        send_beat(cmdec_pkg::FnIoWr, {upper, 8'h0, cmdec_pkg::PortData}, val, 1'($urandom),
                  1'b0, '0);
        if ($urandom_range(0, 1) == 0)
          send_beat(cmdec_pkg::FnIoRd, {16'h0, cmdec_pkg::PortData}, 8'($urandom),
                    1'($urandom), 1'b0, '0);
      end else if (r < 40) begin
        idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255)) :
                                            8'($urandom_range(0, 127));
        send_beat(cmdec_pkg::FnIoWr, {16'h0, cmdec_pkg::PortIndex}, idx, 1'($urandom),
                  1'b0, '0);
        send_beat(cmdec_pkg::FnIoRd, {upper, 8'h0, cmdec_pkg::PortIndex}, 8'($urandom),
                  1'($urandom), 1'b0, '0);
        send_beat(cmdec_pkg::FnIoRd, {16'h0, cmdec_pkg::PortData}, 8'($urandom),
                  1'($urandom), 1'b0, '0);
      end else if (r < 85) begin
        if ($urandom_range(0, 3) != 0) upper = '0;
        r = $urandom_range(0, 99);
        if (r < 15) addr = $urandom_range(0, 32'h9FFFF);
        else if (r < 40) addr = $urandom_range(32'hA0000, 32'hFFFFF);
        else if (r < 65) addr = {upper, 24'($urandom_range(32'h100000, 32'hFDFFFF))};
        else if (r < 75) addr = {upper, 24'($urandom_range(32'hFE0000, 32'hFFFFFF))};
        else addr = $urandom;
        send_beat($urandom_range(0, 1) ? cmdec_pkg::FnMemWr : cmdec_pkg::FnMemRd, addr,
                  8'($urandom), 1'($urandom), 1'b0, '0);
      end else if (r < 93) begin
        repeat ($urandom_range(1, 20))
          send_beat(cmdec_pkg::FnTick, $urandom, 8'($urandom), 1'($urandom), 1'b0, '0);
      end else begin
        addr = $urandom;
        if ($urandom_range(0, 1) == 0)
          addr[15:0] = $urandom_range(0, 1) ? cmdec_pkg::PortIndex : cmdec_pkg::PortData;
        send_beat(3'($urandom_range(0, 7)), addr, 8'($urandom), 1'($urandom), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      route_hits[route_o]++;
      if (expected_routes.size() == 0) begin
        report_mismatch("unexpected beat, route", longint'(route_o), longint'(0));
      end else begin
        seen_want = expected_routes.pop_front();
        if (route_o !== seen_want.route)
          report_mismatch("route", longint'(route_o), longint'(seen_want.route));
        if (target_offset_o !== seen_want.offset)
          report_mismatch("target_offset", longint'(target_offset_o),
                          longint'(seen_want.offset));
        if (data_value_o !== seen_want.data)
          report_mismatch("data_value", longint'(data_value_o), longint'(seen_want.data));
        if (refresh_level_o !== seen_want.refresh)
          report_mismatch("refresh_level", longint'(refresh_level_o),
                          longint'(seen_want.refresh));
      end
    end
  end

  initial begin
    bus_result_t typed_res;
    logic [4:0]  c [4];
    logic [4:0]  mode;
    logic [25:0] total;
    for (int i = 0; i < 8; i++) route_hits[i] = 0;
    reset_decoder_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_config(5'd18, 5'd19, 5'd20, 5'd22, 5'd5, 26'h010_0000);
    foreach (dir_rows[i]) begin
      typed_res.route   = dir_rows[i].rt;
      typed_res.offset  = dir_rows[i].off;
      typed_res.data    = dir_rows[i].dv;
      typed_res.refresh = 1'b0;
      send_beat(dir_rows[i].fn, dir_rows[i].addr, dir_rows[i].din, dir_rows[i].a20,
                dir_rows[i].known, typed_res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        for (int b = 0; b < 4; b++) c[b] = 5'd22;
        mode  = cmdec_pkg::ModeBank31;
        total = 26'd33554432;
      end else if (ph == 1) begin
        for (int b = 0; b < 4; b++) c[b] = 5'd0;
        mode  = 5'd0;
        total = 26'd0;
      end else begin
        for (int b = 0; b < 4; b++)
          c[b] = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(18, 22)) :
                                              5'($urandom_range(0, 22));
        if ($urandom_range(0, 4) < 3)
          mode = $urandom_range(0, 1) ? cmdec_pkg::ModeBank29 : cmdec_pkg::ModeBank31;
        else mode = 5'($urandom);
        total = 26'($urandom_range(0, 33554432));
      end
      load_config(c[0], c[1], c[2], c[3], mode, total);
      gap_pct = (ph < 2) ? 36 : (ph < 4) ? 78 : 0;
      run_random(120);
    end

    quiesce();
    $display("covered %0d beats, %0d results, %0d register loads, directed and random",
             beats_sent, results_seen, config_loads);
    $display("routes: dram %0d rom %0d ext %0d open %0d break %0d internal %0d unclaimed %0d",
             route_hits[cmdec_pkg::RtDram], route_hits[cmdec_pkg::RtRom],
             route_hits[cmdec_pkg::RtExt], route_hits[cmdec_pkg::RtOpen],
             route_hits[cmdec_pkg::RtBreak], route_hits[cmdec_pkg::RtInt],
             route_hits[cmdec_pkg::RtIoun]);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
